// ===== src/mslcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mslcg_pkg
// Shared types and constants for the ranged minimal standard LCG core:
// beat payloads, microcode op and branch codes, and sequencer/datapath links.
// ----------------------------------------------------------------------------
package mslcg_pkg;

   // Generator constants
   localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
   localparam logic [14:0] LCG_MUL  = 15'd16807;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   // Item commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // Microcode addressing
   localparam int unsigned PC_W = 4;

   localparam logic [PC_W-1:0] STEP_FETCH = 4'd0;
   localparam logic [PC_W-1:0] STEP_ADV1  = 4'd1;
   localparam logic [PC_W-1:0] STEP_ADV2  = 4'd2;
   localparam logic [PC_W-1:0] STEP_MULLO = 4'd3;
   localparam logic [PC_W-1:0] STEP_MULHI = 4'd4;
   localparam logic [PC_W-1:0] STEP_ACC   = 4'd5;
   localparam logic [PC_W-1:0] STEP_DIV1  = 4'd6;
   localparam logic [PC_W-1:0] STEP_DIV2  = 4'd7;
   localparam logic [PC_W-1:0] STEP_DIV3  = 4'd8;
   localparam logic [PC_W-1:0] STEP_EMIT  = 4'd9;
   localparam logic [PC_W-1:0] STEP_LOAD  = 4'd10;
   localparam logic [PC_W-1:0] STEP_LAST  = 4'd10;

   // Input beat
   typedef struct packed {
      logic               command;
      logic [31:0]        seed_value;
      logic signed [31:0] lower;
      logic signed [31:0] upper;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [31:0] value;
      logic               range_error;
   } rsp_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_ADV1,
      OP_ADV2,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ACC,
      OP_DIV1,
      OP_DIV2,
      OP_DIV3,
      OP_EMIT,
      OP_LOAD
   } op_type;

   // Sequencer branch conditions
   typedef enum logic [2:0] {
      BR_NEXT,
      BR_ALWAYS,
      BR_IF_LOAD,
      BR_WAIT_REQ,
      BR_WAIT_OUT
   } cond_type;

   // One control word of the program
   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // Sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   fire;
      logic   idle;
   } ctl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic is_load;
      logic out_busy;
   } stat_type;

endpackage

// ===== src/mslcg_seq.sv =====
// ----------------------------------------------------------------------------
// mslcg_seq
// Microcode sequencer: step counter, program ROM and branch logic. Stall
// conditions hold the step and suppress its datapath op.
// ----------------------------------------------------------------------------
module mslcg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  mslcg_pkg::stat_type stat,
   output mslcg_pkg::ctl_type  ctl
);
   import mslcg_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       uw;
   logic            fire;

   // Program ROM
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_NOP, cond: BR_ALWAYS, target: STEP_FETCH};
      case (pc)
         STEP_FETCH: w = '{op: OP_LATCH,  cond: BR_WAIT_REQ, target: STEP_ADV1};
         STEP_ADV1:  w = '{op: OP_ADV1,   cond: BR_IF_LOAD,  target: STEP_LOAD};
         STEP_ADV2:  w = '{op: OP_ADV2,   cond: BR_NEXT,     target: STEP_FETCH};
         STEP_MULLO: w = '{op: OP_MUL_LO, cond: BR_NEXT,     target: STEP_FETCH};
         STEP_MULHI: w = '{op: OP_MUL_HI, cond: BR_NEXT,     target: STEP_FETCH};
         STEP_ACC:   w = '{op: OP_ACC,    cond: BR_NEXT,     target: STEP_FETCH};
         STEP_DIV1:  w = '{op: OP_DIV1,   cond: BR_NEXT,     target: STEP_FETCH};
         STEP_DIV2:  w = '{op: OP_DIV2,   cond: BR_NEXT,     target: STEP_FETCH};
         STEP_DIV3:  w = '{op: OP_DIV3,   cond: BR_NEXT,     target: STEP_FETCH};
         STEP_EMIT:  w = '{op: OP_EMIT,   cond: BR_WAIT_OUT, target: STEP_FETCH};
         STEP_LOAD:  w = '{op: OP_LOAD,   cond: BR_ALWAYS,   target: STEP_FETCH};
         default:    w = '{op: OP_NOP,    cond: BR_ALWAYS,   target: STEP_FETCH};
      endcase
      return w;
   endfunction

   assign uw = ucode_rom(pc_ff);

   // Branch and stall resolution
   always_comb begin
      fire  = 1'b1;
      pc_in = pc_ff + 1'b1;
      case (uw.cond)
         BR_NEXT: begin
            pc_in = pc_ff + 1'b1;
         end
         BR_ALWAYS: begin
            pc_in = uw.target;
         end
         BR_IF_LOAD: begin
            pc_in = stat.is_load ? uw.target : pc_ff + 1'b1;
         end
         BR_WAIT_REQ: begin
            fire  = req_valid;
            pc_in = req_valid ? uw.target : pc_ff;
         end
         BR_WAIT_OUT: begin
            fire  = !stat.out_busy;
            pc_in = stat.out_busy ? pc_ff : uw.target;
         end
         default: begin
            pc_in = STEP_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl.op   = uw.op;
   assign ctl.fire = fire;
   assign ctl.idle = (pc_ff == STEP_FETCH);

   // Checks
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= STEP_LAST)
      else $error("step counter past end of program");

   a_latch_leaves_fetch: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && ctl.op == OP_LATCH) |=> (pc_ff == STEP_ADV1))
      else $error("accepted beat did not start the program");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_EMIT && stat.out_busy) |=> (pc_ff == STEP_EMIT))
      else $error("result step left while output register full");

endmodule

// ===== src/mslcg_dp.sv =====
// ----------------------------------------------------------------------------
// mslcg_dp
// Datapath: seed register, split constant multiply with end-around fold,
// shared 31x17 range multiplier, divide by 2^31-1 by folding, result register.
// ----------------------------------------------------------------------------
module mslcg_dp (
   input  logic               clock,
   input  logic               reset,
   input  mslcg_pkg::ctl_type ctl,
   input  mslcg_pkg::req_type req_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output mslcg_pkg::rsp_type rsp_data,
   output mslcg_pkg::stat_type stat
);
   import mslcg_pkg::*;

   // Registers
   req_type     req_ff,       req_in;
   logic [30:0] seed_ff,      seed_in;
   logic [31:0] t_ff,         t_in;
   logic [32:0] n_ff,         n_in;
   logic        err_ff,       err_in;
   logic [47:0] prod_ff,      prod_in;
   logic [62:0] acc_ff,       acc_in;
   logic [32:0] q_ff,         q_in;
   logic [32:0] r_ff,         r_in;
   rsp_type     rsp_ff,       rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Combinational helpers
   logic [30:0] adv_lo;
   logic [29:0] adv_hi;
   logic [32:0] sum1;
   logic [32:0] sum2;
   logic [32:0] fold1;
   logic [32:0] fold2;
   logic [16:0] mul_sel;
   logic [47:0] mul_prod;
   logic [30:0] load_seed;
   logic [31:0] lower_b;
   logic [31:0] upper_b;
   logic        out_busy;
   logic        emit_fire;

   // End-around fold modulo 2^31-1
   function automatic logic [32:0] fold31(input logic [32:0] x);
      logic [32:0] y;
      y = x;
      if (x > {2'b00, LCG_MOD}) begin
         y = (x & {2'b00, LCG_MOD}) + 33'd1;
      end
      return y;
   endfunction

   // Seed step: 16807 * seed split into 16-bit and 15-bit halves
   assign adv_lo = {16'd0, LCG_MUL} * {15'd0, seed_ff[15:0]};
   assign adv_hi = {15'd0, LCG_MUL} * {15'd0, seed_ff[30:16]};
   assign sum1   = {2'b00, adv_lo} + {2'b00, adv_hi[14:0], 16'd0};
   assign fold1  = fold31(sum1);
   assign sum2   = {1'b0, t_ff} + {18'd0, adv_hi[29:15]};
   assign fold2  = fold31(sum2);

   // Shared range multiplier, low then high part of n
   assign mul_sel  = (ctl.op == OP_MUL_LO) ? {1'b0, n_ff[15:0]} : n_ff[32:16];
   assign mul_prod = {17'd0, seed_ff} * {31'd0, mul_sel};

   // Load value: all-zero and all-one patterns are not valid seeds
   assign load_seed = ((req_ff.seed_value[30:0] == 31'd0) ||
                       (req_ff.seed_value[30:0] == LCG_MOD)) ?
                      31'd1 : req_ff.seed_value[30:0];

   // Offset binary for the span
   assign lower_b = $unsigned(req_ff.lower) ^ SIGN_BIT;
   assign upper_b = $unsigned(req_ff.upper) ^ SIGN_BIT;

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign emit_fire = ctl.fire && (ctl.op == OP_EMIT);

   // Next-state logic
   always_comb begin
      req_in  = req_ff;
      seed_in = seed_ff;
      t_in    = t_ff;
      n_in    = n_ff;
      err_in  = err_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      rsp_in  = rsp_ff;
      if (ctl.fire) begin
         case (ctl.op)
            OP_LATCH: begin
               req_in = req_data;
            end
            OP_ADV1: begin
               t_in   = fold1[31:0];
               n_in   = {1'b0, upper_b} - {1'b0, lower_b} + 33'd1;
               err_in = (req_ff.upper < req_ff.lower);
            end
            OP_ADV2: begin
               seed_in = fold2[30:0];
            end
            OP_MUL_LO: begin
               prod_in = mul_prod;
            end
            OP_MUL_HI: begin
               acc_in  = {15'd0, prod_ff};
               prod_in = mul_prod;
            end
            OP_ACC: begin
               acc_in = acc_ff + {prod_ff[46:0], 16'd0};
            end
            OP_DIV1: begin
               q_in = {1'b0, acc_ff[62:31]};
               r_in = {2'b00, acc_ff[30:0]} + {1'b0, acc_ff[62:31]};
            end
            OP_DIV2: begin
               q_in = q_ff + {31'd0, r_ff[32:31]};
               r_in = {2'b00, r_ff[30:0]} + {31'd0, r_ff[32:31]};
            end
            OP_DIV3: begin
               if (r_ff >= {2'b00, LCG_MOD}) begin
                  q_in = q_ff + 33'd1;
               end
            end
            OP_EMIT: begin
               rsp_in.range_error = err_ff;
               rsp_in.value       = err_ff ? req_ff.lower : req_ff.lower + q_ff[31:0];
            end
            OP_LOAD: begin
               seed_in = load_seed;
            end
            default: begin
               req_in = req_ff;
            end
         endcase
      end
   end

   // Output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= 31'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      t_ff    <= t_in;
      n_ff    <= n_in;
      err_ff  <= err_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.is_load  = (req_ff.command == CMD_LOAD);
   assign stat.out_busy = out_busy;

   // Checks
   a_seed_legal: assert property (@(posedge clock) disable iff (reset)
      (seed_ff != 31'd0) && (seed_ff != LCG_MOD))
      else $error("seed left the cycle of the generator");

   a_quot_fits: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !err_ff) |-> (q_ff[32] == 1'b0))
      else $error("range quotient overflowed 32 bits");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !err_ff) |-> (r_ff <= ({2'b00, LCG_MOD} + 33'd2)))
      else $error("remainder fold did not converge");

endmodule

// ===== src/minimal_standard_lcg_ranged_core.sv =====
// ----------------------------------------------------------------------------
// minimal_standard_lcg_ranged_core
// Minimal standard multiplicative generator (seed * 16807 mod 2^31-1) with
// exact integer mapping of each draw onto lower..upper.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_valid / req_ready  | req_data: command, seed_value, lower, upper
//  rsp     | out | rsp_valid / rsp_ready  | rsp_data: value, range_error
//
//  A draw runs the program from the fetch step through the seed advance, the
//  range multiply, the fold divide and the result step; rsp_valid rises in the
//  same cycle as req_ready returns. A load runs the first seed step and the load
//  step. Both are set by the microcode program (one datapath op per step).
//  req_ready is high only while the sequencer sits at its fetch step.
//  Reset (synchronous, active high) sets the seed to 1 and empties the output.
//  A full output register stalls the result step; the next beat is taken in
//  the cycle after the result has been written into the output register.
// ----------------------------------------------------------------------------
module minimal_standard_lcg_ranged_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mslcg_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output mslcg_pkg::rsp_type rsp_data
);
   import mslcg_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   mslcg_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctl       (ctl)
   );

   mslcg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

   assign req_ready = ctl.idle;

endmodule

// ===== verif/minimal_standard_lcg_ranged_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minimal_standard_lcg_ranged_core_tb
// Self-checking bench for the ranged LCG core. A scoreboard class tracks its
// own copy of the 31-bit seed, advances it on every accepted draw and maps it
// onto lower..upper to build the expected result; each result beat is checked
// in order against it. Directed corner items come first, then random loads
// and draws with random gaps on the request side and stalls on the response
// side.
// ----------------------------------------------------------------------------
import mslcg_pkg::*;

class draw_scoreboard;
   logic [30:0] gen_state;
   rsp_type     pending_draws[$];
   int          failures;

   function new();
      gen_state = 31'd1;
      failures  = 0;
   endfunction

   // end-around fold modulo 2^31-1
   function logic [63:0] fold_mod(logic [63:0] x);
      if (x > {33'b0, LCG_MOD})
         return (x & {33'b0, LCG_MOD}) + 64'd1;
      return x;
   endfunction

   // Update the seed for an accepted beat and queue the expected draw
   function void note_item(req_type item);
      logic [63:0] prod_lo, prod_hi, acc, span, scaled;
      logic [31:0] lo_off, hi_off;
      rsp_type     want;
      if (item.command == CMD_LOAD) begin
         gen_state = item.seed_value[30:0];
         if (gen_state == 31'd0 || gen_state == LCG_MOD)
            gen_state = 31'd1;
      end else begin
         prod_lo   = {49'b0, LCG_MUL} * {48'b0, gen_state[15:0]};
         prod_hi   = {49'b0, LCG_MUL} * {49'b0, gen_state[30:16]};
         acc       = fold_mod(prod_lo + ({49'b0, prod_hi[14:0]} << 16));
         acc       = fold_mod(acc + (prod_hi >> 15));
         gen_state = acc[30:0];
         // bias by the sign bit so an unsigned compare orders signed bounds
         lo_off = item.lower ^ SIGN_BIT;
         hi_off = item.upper ^ SIGN_BIT;
         if (hi_off < lo_off) begin
            want.value       = item.lower;
            want.range_error = 1'b1;
         end else begin
            span             = {32'b0, hi_off - lo_off} + 64'd1;
            scaled           = ({33'b0, gen_state} * span) / {33'b0, LCG_MOD};
            want.value       = item.lower + scaled[31:0];
            want.range_error = 1'b0;
         end
         pending_draws = {pending_draws, want};
      end
   endfunction

   // Compare one result beat with the oldest expected draw
   function void check_draw(rsp_type got);
      rsp_type want;
      if (pending_draws.size() == 0) begin
         $error("unexpected result beat: value %0d range_error %0b",
                got.value, got.range_error);
         failures++;
         return;
      end
      want = pending_draws.pop_front();
      if (got.value !== want.value) begin
         $error("value: expected %0d, got %0d", want.value, got.value);
         failures++;
      end
      if (got.range_error !== want.range_error) begin
         $error("range_error: expected %0b, got %0b", want.range_error,
                got.range_error);
         failures++;
      end
   endfunction
endclass

module minimal_standard_lcg_ranged_core_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_TICKS = 30;
   localparam int RAND_ITEMS  = 1200;

   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   draw_scoreboard sb;
   bit calm       = 1'b0;  // no gaps or stalls while set
   int stall_left = 0;
   int idle_ticks = 0;

   minimal_standard_lcg_ranged_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Monitor both channels, drive rsp_ready stalls, watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_ticks = 0;
      end else begin
         if (req_valid && req_ready)
            sb.note_item(req_data);
         if (rsp_valid && rsp_ready) begin
            sb.check_draw(rsp_data);
            stall_left = calm ? 0 : $urandom_range(0, 3);
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_ticks = 0;
         else
            idle_ticks = idle_ticks + 1;
         if (idle_ticks >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
      rsp_ready <= (stall_left == 0);
   end

   // Present one beat after a random gap and hold it until accepted
   task automatic send_item(req_type item);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type make_draw(logic signed [31:0] lo,
                                         logic signed [31:0] hi);
      req_type item;
      item.command    = CMD_DRAW;
      item.seed_value = $urandom;
      item.lower      = lo;
      item.upper      = hi;
      return item;
   endfunction

   function automatic req_type make_load(logic [31:0] seed_bits);
      req_type item;
      item.command    = CMD_LOAD;
      item.seed_value = seed_bits;
      item.lower      = $urandom;
      item.upper      = $urandom;
      return item;
   endfunction

   // Random bound, weighted toward the extremes and near zero
   function automatic logic signed [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0:       return INT_MIN;
         1:       return INT_MAX;
         2:       return $signed($urandom_range(0, 16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_item();
      logic signed [31:0] lo;
      logic [31:0]        seed_bits;
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 7))
            0:       seed_bits = 32'h0000_0000;
            1:       seed_bits = 32'h7FFF_FFFF;
            2:       seed_bits = 32'hFFFF_FFFF;
            3:       seed_bits = 32'h8000_0000;
            default: seed_bits = $urandom;
         endcase
         return make_load(seed_bits);
      end
      lo = pick_bound();
      case ($urandom_range(0, 4))
         0:       return make_draw(lo, lo + $urandom_range(0, 15));
         1:       return make_draw(lo, lo);
         2:       return make_draw(INT_MIN, INT_MAX);
         default: return make_draw(lo, pick_bound());
      endcase
   endfunction

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed corners
      send_item(make_draw(0, 9));                  // seed straight from reset
      send_item(make_load(32'h0000_0000));         // zero seed becomes one
      send_item(make_draw(0, 9));
      send_item(make_load(32'h7FFF_FFFF));         // seed equal to modulus
      send_item(make_draw(0, 9));
      send_item(make_load(32'hFFFF_FFFF));         // upper bit dropped, then modulus
      send_item(make_draw(-100, 100));
      send_item(make_load(32'h8000_0000));         // masks down to zero
      send_item(make_draw(INT_MIN, INT_MAX));
      send_item(make_load(32'h7FFF_FFFE));         // largest legal seed
      send_item(make_draw(INT_MIN, INT_MAX));      // full range
      send_item(make_draw(INT_MIN, INT_MAX));
      send_item(make_draw(5, 4));                  // reversed range
      send_item(make_draw(INT_MAX, INT_MIN));
      send_item(make_draw(INT_MIN, INT_MIN));      // single-value ranges
      send_item(make_draw(INT_MAX, INT_MAX));
      send_item(make_draw(0, INT_MAX));
      send_item(make_draw(INT_MIN, -1));
      send_item(make_draw(-1, 0));
      send_item(make_load(32'h5555_5555));
      send_item(make_draw(INT_MAX - 1, INT_MAX));
      send_item(make_load(32'hAAAA_AAAA));
      send_item(make_draw(0, 1));

      // Random mix, with a gap-free stretch in the middle
      for (int i = 0; i < RAND_ITEMS; i++) begin
         calm = (i >= 500 && i < 650);
         send_item(random_item());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
      if (sb.pending_draws.size() != 0) begin
         $error("%0d expected results never arrived", sb.pending_draws.size());
         sb.failures++;
      end

      if (sb.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
src/mslcg_pkg.sv
src/mslcg_seq.sv
src/mslcg_dp.sv
src/minimal_standard_lcg_ranged_core.sv
verif/minimal_standard_lcg_ranged_core_tb.sv
